[src/ntc_lut_pkg.sv]
package ntc_lut_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 91;
   localparam int ROM_WORDS             = 91;
   localparam int ROM_ADDR_W            = $clog2(ROM_WORDS);
   localparam int SUM_W                 = 15;
   localparam int TEMP_W                = 10;
   localparam int ALU_W                 = 20;
   localparam int ROM_IDX_W             = 8;

   localparam logic signed [TEMP_W-1:0] TEMP_BELOW_FIRST = -10'sd400;
   localparam logic signed [TEMP_W-1:0] TEMP_ABOVE_LAST  = 10'sd500;

   localparam logic [SUM_W-1:0] ROM_SUMS [0:ROM_WORDS-1] = '{
      15'd31184, 15'd31088, 15'd31024, 15'd30928, 15'd30832, 15'd30736, 15'd30624,
      15'd30528, 15'd30432, 15'd30320, 15'd30208, 15'd30080, 15'd29968, 15'd29840,
      15'd29712, 15'd29584, 15'd29456, 15'd29296, 15'd29168, 15'd29008, 15'd28880,
      15'd28720, 15'd28560, 15'd28416, 15'd28240, 15'd28080, 15'd27920, 15'd27744,
      15'd27584, 15'd27408, 15'd27232, 15'd27040, 15'd26880, 15'd26688, 15'd26496,
      15'd26304, 15'd26144, 15'd25952, 15'd25760, 15'd25568, 15'd25376, 15'd25184,
      15'd24992, 15'd24800, 15'd24608, 15'd24416, 15'd24224, 15'd24032, 15'd23840,
      15'd23648, 15'd23472, 15'd23280, 15'd23104, 15'd22912, 15'd22736, 15'd22560,
      15'd22368, 15'd22192, 15'd22032, 15'd21840, 15'd21680, 15'd21504, 15'd21344,
      15'd21168, 15'd21008, 15'd20848, 15'd20688, 15'd20528, 15'd20368, 15'd20224,
      15'd20080, 15'd19936, 15'd19776, 15'd19648, 15'd19488, 15'd19360, 15'd19232,
      15'd19104, 15'd18976, 15'd18848, 15'd18720, 15'd18608, 15'd18480, 15'd18368,
      15'd18256, 15'd18144, 15'd18048, 15'd17936, 15'd17824, 15'd17728, 15'd17632
   };

   // Indexes past the stored words read the last word.
   function automatic logic [SUM_W-1:0] rom_read(input logic [ROM_IDX_W-1:0] idx);
      logic [ROM_IDX_W-1:0] i;
      i = (idx >= ROM_IDX_W'(ROM_WORDS)) ? ROM_IDX_W'(ROM_WORDS - 1) : idx;
      return ROM_SUMS[ROM_ADDR_W'(i)];
   endfunction

   // Temperature of table entry idx: -400 plus 10 per step, wrapped to 10 bits.
   function automatic logic [TEMP_W-1:0] temp_at(input logic [ROM_IDX_W-1:0] idx);
      logic [15:0] t;
      t = 16'(idx) * 16'd10 - 16'd400;
      return t[TEMP_W-1:0];
   endfunction

endpackage

[src/ntc_table_temperature_lookup.sv]
// NTC thermistor table lookup: sum of 32 ADC samples in, temperature in
// tenths of a degree Celsius out.
//
// Request channel: req_adc_sum is taken at a rising edge where start is high
// and busy is low. busy stays high from the following cycle until the
// conversion finishes.
// Response channel: rsp_temperature_tenths is valid for exactly one cycle,
// marked by rsp_strobe. The receiver cannot stall; it must take the
// response in that cycle.
//
// Sequence after the accepting edge: a sum at or below the last entry is
// answered after the first range check, a sum at or above the first entry
// after the second; a sum between entries passes two range checks, up to
// ceil(log2(TABLE_ENTRIES - 1)) search steps plus one exit step, three setup
// steps and four restoring-division steps. All steps share one subtract/compare
// unit. One request is in flight at a time; busy drops in the cycle the
// response is shown, so the next request may be taken at that edge.
//
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any pending response strobe.
module ntc_table_temperature_lookup #(
   parameter int TABLE_ENTRIES = ntc_lut_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic        [ntc_lut_pkg::SUM_W-1:0]        req_adc_sum,
   output logic                                        rsp_strobe,
   output logic signed [ntc_lut_pkg::TEMP_W-1:0]       rsp_temperature_tenths
);

   localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int W     = ntc_lut_pkg::ALU_W;
   localparam int SW    = ntc_lut_pkg::SUM_W;
   localparam int TW    = ntc_lut_pkg::TEMP_W;
   localparam int RW    = ntc_lut_pkg::ROM_IDX_W;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CHK_LAST  = 8'b0000_0010,
      ST_CHK_FIRST = 8'b0000_0100,
      ST_SEARCH    = 8'b0000_1000,
      ST_READ_L    = 8'b0001_0000,
      ST_GAP       = 8'b0010_0000,
      ST_DIFF      = 8'b0100_0000,
      ST_DIV       = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [SW-1:0]     gap_ff, gap_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [3:0]        q_ff, q_in;
   logic [1:0]        k_ff, k_in;
   logic [TW-1:0]     result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [W-1:0]      alu_a, alu_b, alu_diff;
   logic              alu_ge;
   logic [IDX_W:0]    idx_sum;
   logic [IDX_W-1:0]  mid;
   logic              span_open;
   logic [SW-1:0]     rom_lo, rom_hi, rom_mid, rom_first;
   logic [SW-1:0]     x;
   logic [3:0]        q_next;

   ntc_lut_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .a_ge_b (alu_ge)
   );

   // Midpoint and table reads of the current bracket.
   assign idx_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = idx_sum[IDX_W:1];
   assign span_open = (hi_ff - lo_ff) > IDX_W'(1);
   assign rom_lo    = ntc_lut_pkg::rom_read(RW'(lo_ff));
   assign rom_hi    = ntc_lut_pkg::rom_read(RW'(hi_ff));
   assign rom_mid   = ntc_lut_pkg::rom_read(RW'(mid));
   assign rom_first = ntc_lut_pkg::rom_read(RW'(0));
   assign x         = alu_diff[SW-1:0];
   assign q_next    = alu_ge ? (q_ff | (4'd1 << k_ff)) : q_ff;

   // Steer the shared unit for each sequencer step.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         ST_CHK_LAST: begin
            alu_a = W'(rom_hi);
            alu_b = W'(sum_ff);
         end
         ST_CHK_FIRST: begin
            alu_a = W'(sum_ff);
            alu_b = W'(rom_first);
         end
         ST_SEARCH: begin
            alu_a = W'(rom_mid);
            alu_b = W'(sum_ff);
         end
         ST_READ_L: begin
            alu_a = W'(sum_ff);
            alu_b = W'(rom_lo);
         end
         ST_GAP: begin
            alu_a = W'(rom_lo);
            alu_b = W'(rom_hi);
         end
         ST_DIFF: begin
            alu_a = W'(sum_ff);
            alu_b = W'(rom_hi);
         end
         ST_DIV: begin
            alu_a = rem_ff;
            alu_b = W'(gap_ff) << k_ff;
         end
         ST_IDLE: begin
            alu_a = '0;
            alu_b = '0;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      gap_in       = gap_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      result_in    = result_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               sum_in   = req_adc_sum;
               lo_in    = '0;
               hi_in    = IDX_W'(TABLE_ENTRIES - 1);
               state_in = ST_CHK_LAST;
            end
         end
         // Sum at or below the last entry: clamp hot.
         ST_CHK_LAST: begin
            if (alu_ge) begin
               result_in    = ntc_lut_pkg::TEMP_ABOVE_LAST;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_CHK_FIRST;
            end
         end
         // Sum at or above the first entry: clamp cold.
         ST_CHK_FIRST: begin
            if (alu_ge) begin
               result_in    = ntc_lut_pkg::TEMP_BELOW_FIRST;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         // Halve the bracket; table descends, so a larger sum moves hi down.
         ST_SEARCH: begin
            if (span_open) begin
               if (!alu_ge) begin
                  hi_in = mid;
               end else begin
                  lo_in = mid;
               end
            end else begin
               state_in = ST_READ_L;
            end
         end
         // Exact hit on the left entry: no interpolation.
         ST_READ_L: begin
            if (alu_ge) begin
               result_in    = ntc_lut_pkg::temp_at(RW'(lo_ff));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            gap_in = alu_diff[SW-1:0];
            if (!alu_ge || (alu_diff == '0)) begin
               result_in    = ntc_lut_pkg::temp_at(RW'(hi_ff));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DIFF;
            end
         end
         // Dividend: 10 * (sum - right) + gap / 2, for round half up.
         ST_DIFF: begin
            rem_in   = (W'(x) << 3) + (W'(x) << 1) + W'(gap_ff >> 1);
            q_in     = '0;
            k_in     = 2'd3;
            state_in = ST_DIV;
         end
         // Restoring division, one quotient bit per cycle; quotient is at most 10.
         ST_DIV: begin
            if (alu_ge) begin
               rem_in = alu_diff;
            end
            q_in = q_next;
            if (k_ff == 2'd0) begin
               result_in    = ntc_lut_pkg::temp_at(RW'(hi_ff)) - TW'(q_next);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               k_in = k_ff - 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers hold without reset.
   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      gap_ff    <= gap_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
      result_ff <= result_in;
   end

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_strobe             = rsp_valid_ff;
   assign rsp_temperature_tenths = result_ff;

endmodule

[src/ntc_lut_alu.sv]
module ntc_lut_alu (
   input  logic [ntc_lut_pkg::ALU_W-1:0] op_a,
   input  logic [ntc_lut_pkg::ALU_W-1:0] op_b,
   output logic [ntc_lut_pkg::ALU_W-1:0] diff,
   output logic                          a_ge_b
);

   logic [ntc_lut_pkg::ALU_W:0] full;

   // Subtract with one guard bit; no borrow means op_a >= op_b.
   assign full   = {1'b0, op_a} - {1'b0, op_b};
   assign diff   = full[ntc_lut_pkg::ALU_W-1:0];
   assign a_ge_b = ~full[ntc_lut_pkg::ALU_W];

endmodule
